/* sv/dis_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the descending insertion sorter.
// No dependencies.
package dis_pkg;

  // Number of cells in the chain, which is the store capacity
  localparam int DEPTH    = 64;
  // Key width, which matches the key fields of the words
  localparam int KEY_BITS = 16;

  typedef logic [KEY_BITS-1:0] key_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic valid;  // cell holds a key
    logic take;   // cell is taking a new or shifted key on insert
    key_t key;    // stored key
  } cell_link_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic insert;     // insert new_key this cycle
    logic shift_out;  // pop cell 0, shift the chain toward cell 0
    key_t new_key;    // key being inserted
  } cell_ctrl_t;

endpackage

/* sv/dis_in_if.sv */
`timescale 1ns / 1ps
// Input channel of the sorter: valid/ready plus one key word.
// Depends on dis_pkg.
interface dis_in_if import dis_pkg::*; ();
  logic valid;
  logic ready;
  key_t key_in;
  logic end_of_set;

  modport source(output valid, output key_in, output end_of_set, input ready);
  modport sink(input valid, input key_in, input end_of_set, output ready);
endinterface

/* sv/dis_out_if.sv */
`timescale 1ns / 1ps
// Output channel of the sorter: valid/ready plus one sorted key word.
// Depends on dis_pkg.
interface dis_out_if import dis_pkg::*; ();
  logic valid;
  logic ready;
  key_t key_out;
  logic final_result;
  logic overflow;

  modport source(output valid, output key_out, output final_result, output overflow,
                 input ready);
  modport sink(input valid, input key_out, input final_result, input overflow,
               output ready);
endinterface

/* sv/descending_insertion_sorter.sv */
`timescale 1ns / 1ps
// Top level of the descending stable insertion sorter: cell chain and control.
// Depends on dis_pkg, dis_in_if, dis_out_if and dis_cell.

// Keys enter one word per cycle into a chain of DEPTH cells that keeps them
// sorted largest first; equal keys keep their arrival order. The word marked
// end_of_set is inserted like the others and then starts the drain: from the
// next cycle on, the n stored keys leave one word per cycle (as the sink
// takes them) from cell 0 while the chain shifts toward it, with final_result
// on the last one and overflow on all of them if keys were dropped because
// the chain was full. Input is held off from the end_of_set word until the
// last result is taken, so the next set cannot load while the stored keys
// (at most DEPTH) drain out. No clearing pass is needed after reset.
module descending_insertion_sorter import dis_pkg::*; (
  input logic      clk,
  input logic      rst,
  dis_in_if.sink   keys_in,
  dis_out_if.source keys_out
);

  cell_link_t link [DEPTH];
  cell_ctrl_t ctrl;
  cell_link_t head;
  cell_link_t tail;

  logic draining;
  logic draining_next;
  logic dropped;
  logic dropped_next;
  logic in_fire;
  logic out_fire;
  logic full;
  logic last_pop;

  // Handshake and chain status
  assign keys_in.ready = !draining;
  assign in_fire       = keys_in.valid && keys_in.ready;
  assign out_fire      = keys_out.valid && keys_out.ready;
  assign full          = link[DEPTH-1].valid;
  assign last_pop      = out_fire && !link[1].valid;

  // Broadcast control
  assign ctrl.insert    = in_fire && !full;
  assign ctrl.shift_out = out_fire;
  assign ctrl.new_key   = keys_in.key_in;

  // Ends of the chain: a taking cell 0 loads the new key, the tail feeds empties
  assign head.valid = 1'b1;
  assign head.take  = 1'b0;
  assign head.key   = '0;
  assign tail.valid = 1'b0;
  assign tail.take  = 1'b0;
  assign tail.key   = '0;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t prev_l;
    cell_link_t next_l;
    if (i == 0) begin : g_first
      assign prev_l = head;
    end else begin : g_prev
      assign prev_l = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_l = tail;
    end else begin : g_next
      assign next_l = link[i+1];
    end
    dis_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .prev (prev_l),
      .next (next_l),
      .self (link[i])
    );
  end

  // Drain and drop flags
  always_comb begin
    draining_next = draining;
    dropped_next  = dropped;
    if (in_fire && full) begin
      dropped_next = 1'b1;
    end
    if (in_fire && keys_in.end_of_set) begin
      draining_next = 1'b1;
    end
    if (last_pop) begin
      draining_next = 1'b0;
      dropped_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      draining <= draining_next;
      dropped  <= dropped_next;
    end
  end

  // Result word: key straight from cell 0, flags from cell 1 and the drop flag
  assign keys_out.valid        = draining;
  assign keys_out.key_out      = link[0].key;
  assign keys_out.final_result = !link[1].valid;
  assign keys_out.overflow     = dropped;

`ifndef SYNTH
  // A drain always has a key in cell 0
  a_drain_has_key: assert property (@(posedge clk) disable iff (rst)
    draining |-> link[0].valid)
    else $error("drain with empty cell 0");

  // The end-of-set word starts a drain
  a_end_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (in_fire && keys_in.end_of_set) |=> draining)
    else $error("end of set did not start drain");

  // Taking the final result ends the drain and leaves the chain empty
  a_final_empties: assert property (@(posedge clk) disable iff (rst)
    (out_fire && keys_out.final_result) |=> (!draining && !link[0].valid && !dropped))
    else $error("chain not empty after final result");

  // An empty cell 0 means an empty last cell, as when valid cells form a prefix of the chain
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    !link[0].valid |-> !link[DEPTH-1].valid)
    else $error("valid cells are not a prefix");
`endif

endmodule

/* sv/dis_cell.sv */
`timescale 1ns / 1ps
// One cell of the insertion chain: holds one key and its valid bit.
// Depends on dis_pkg.
module dis_cell import dis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_link_t prev,   // neighbor toward the largest key
  input  cell_link_t next,   // neighbor toward the smallest key
  output cell_link_t self
);

  logic valid;
  key_t key;
  logic take;

  // A cell takes part in the insert when it is empty or holds a smaller key;
  // equal keys stay put so the new key lands behind them.
  assign take = !valid || (key < ctrl.new_key);

  assign self.valid = valid;
  assign self.take  = take;
  assign self.key   = key;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift_out) begin
      valid <= next.valid;
    end else if (ctrl.insert) begin
      valid <= valid | prev.valid;
    end
  end

  // Key: shifted from the larger neighbor, the new key, or from the smaller one
  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      key <= next.key;
    end else if (ctrl.insert && take) begin
      key <= prev.take ? prev.key : ctrl.new_key;
    end
  end

endmodule

/* tb/descending_insertion_sorter_tb.sv */
`timescale 1ns / 1ps
// Testbench for descending_insertion_sorter: random and directed key sets, checked
// word by word against a stable descending sort kept in a small scoreboard class.
// Depends on dis_pkg, dis_in_if, dis_out_if and the sorter RTL.
module descending_insertion_sorter_tb import dis_pkg::*; ();

  localparam int RANDOM_KEYS  = 256;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 2 * DEPTH;

  typedef struct packed {
    key_t key;
    logic final_result;
    logic overflow;
  } sorted_word_t;

  // Keeps the set being loaded in sorted order and the words still owed by the block
  class sort_scoreboard;
    key_t         set_keys[$];
    bit           set_dropped;
    sorted_word_t owed_words[$];
    int           errors;

    // Stable descending insert; an end mark turns the set into owed words
    function void note_key(key_t k, logic eos);
      int pos;
      sorted_word_t w;
      if (set_keys.size() >= DEPTH) begin
        set_dropped = 1'b1;
      end else begin
        pos = set_keys.size();
        while (pos > 0 && set_keys[pos-1] < k) pos--;
        set_keys.insert(pos, k);
      end
      if (eos) begin
        foreach (set_keys[i]) begin
          w.key          = set_keys[i];
          w.final_result = (i == set_keys.size() - 1);
          w.overflow     = set_dropped;
          owed_words.push_back(w);
        end
        set_keys.delete();
        set_dropped = 1'b0;
      end
    endfunction

    // Compare one output word with the oldest owed one
    function void check_word(key_t k, logic fin, logic ovf);
      sorted_word_t w;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word key=%h final=%b overflow=%b", $time, k, fin, ovf);
        errors++;
        return;
      end
      w = owed_words.pop_front();
      if (k !== w.key) begin
        $display("%0t: key_out expected %h actual %h", $time, w.key, k);
        errors++;
      end
      if (fin !== w.final_result) begin
        $display("%0t: final_result expected %b actual %b", $time, w.final_result, fin);
        errors++;
      end
      if (ovf !== w.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, w.overflow, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  dis_in_if  keys_in_if();
  dis_out_if keys_out_if();

  descending_insertion_sorter uut (
    .clk      (clk),
    .rst      (rst),
    .keys_in  (keys_in_if),
    .keys_out (keys_out_if)
  );

  sort_scoreboard sb = new();

  int src_idle_pct = 23;
  int snk_idle_pct = 49;
  int hold_req     = 0;
  int keys_sent    = 0;

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sample both channels at the edge where a word moves
  always @(posedge clk) begin
    if (!rst) begin
      if (keys_in_if.valid && keys_in_if.ready)
        sb.note_key(keys_in_if.key_in, keys_in_if.end_of_set);
      if (keys_out_if.valid && keys_out_if.ready)
        sb.check_word(keys_out_if.key_out, keys_out_if.final_result, keys_out_if.overflow);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    keys_out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        keys_out_if.ready <= 1'b0;
      end else begin
        keys_out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Mix of extremes, narrow range for ties, and full random
  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return key_t'($urandom_range(0, 7));
      default: return key_t'($urandom);
    endcase
  endfunction

  // Offer one word after optional idle cycles, return at acceptance
  task automatic send_word(input key_t k, input logic eos);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      keys_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    keys_in_if.valid      <= 1'b1;
    keys_in_if.key_in     <= k;
    keys_in_if.end_of_set <= eos;
    @(posedge clk);
    while (!keys_in_if.ready) @(posedge clk);
    keys_sent++;
  endtask

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_word(pick_key(), i == n - 1);
  endtask

  // Stop offering and wait until every owed word has come out
  task automatic wait_drained();
    keys_in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    int set_no;
    int set_len;
    int random_start;
    bit drained_pause_done;
    set_no = 0;
    drained_pause_done = 1'b0;
    rst <= 1'b1;
    keys_in_if.valid      <= 1'b0;
    keys_in_if.key_in     <= '0;
    keys_in_if.end_of_set <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-key sets at both extremes
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    // Ascending arrival comes out reversed
    send_word(16'h0001, 1'b0);
    send_word(16'h0002, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'h0004, 1'b1);
    // Already descending, with both halves of the range
    send_word(16'hFFFF, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0000, 1'b1);
    // Equal keys mixed in
    send_word(16'h0005, 1'b0);
    send_word(16'h0005, 1'b0);
    send_word(16'h0009, 1'b0);
    send_word(16'h0005, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0009, 1'b1);
    // Alternating bit patterns
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b1);

    // Random sets; one full store and one overflowing set along the way
    random_start = keys_sent;
    while (keys_sent - random_start < RANDOM_KEYS) begin
      if (keys_sent - random_start >= 2 * RANDOM_KEYS / 3) begin
        if (!drained_pause_done) begin
          wait_drained();
          drained_pause_done = 1'b1;
        end
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (keys_sent - random_start >= RANDOM_KEYS / 3) begin
        src_idle_pct = 49;
        snk_idle_pct = 23;
      end
      if (set_no == 2)
        set_len = DEPTH;
      else if (set_no == 5)
        set_len = DEPTH + $urandom_range(1, 3);
      else if ($urandom_range(0, 9) < 9)
        set_len = $urandom_range(1, 8);
      else
        set_len = $urandom_range(9, 24);
      // Long receiver hold-off while input keeps coming
      if (set_no == 8) hold_req = 1;
      send_random_set(set_len);
      set_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
